@@ rtl/mmx_pkg.sv @@
// Shared types and constants of the metatile map expander.
// Depends on nothing; the front, back and top files and the testbench refer to it by scoped names.
package mmx_pkg;

  localparam int unsigned MAP_BYTES_DFLT = 16384;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 11;
  localparam int unsigned CMDQ_DEPTH     = 2;
  localparam int unsigned RESQ_DEPTH     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_HAS_UPPER   = 3'd2,
    REG_USE_PLANE_A = 3'd3,
    REG_BYTE_TILES  = 3'd4,
    REG_TILE_BASE   = 3'd5
  } mmx_reg_e;

  // Map dimensions are already clamped to 1..256 here.
  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic        has_upper;
    logic        use_plane_a;
    logic        byte_tiles;
    logic [10:0] tile_base;
  } mmx_cfg_t;

  typedef struct packed {
    logic       is_load;
    logic [7:0] data;
    logic [4:0] col_half;
    logic [3:0] row_half;
    logic       layer;
    logic       zero_tile;
  } mmx_cmd_t;

  typedef struct packed {
    logic        plane;
    logic [5:0]  column;
    logic [4:0]  row;
    logic [10:0] tile_index;
    logic        last;
  } mmx_res_t;

endpackage

@@ rtl/mmx_fifo.sv @@
// Small register queue used between the front and back part and at the result side.
// Depends on nothing outside this file.
module mmx_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue holds more items than its depth");

endmodule

@@ rtl/mmx_front.sv @@
// Front part: accepts items, wraps the map cell and forms the store address.
// Depends on mmx_pkg for the configuration and command types.
module mmx_front #(
  parameter int unsigned MAP_BYTES = mmx_pkg::MAP_BYTES_DFLT,
  localparam int unsigned AW       = $clog2(MAP_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mmx_pkg::mmx_cfg_t cfg_i,
  input  logic             push_i,
  output logic             full_o,
  input  logic             mode_i,
  input  logic [13:0]      load_address_i,
  input  logic [7:0]       load_byte_i,
  input  logic [15:0]      cell_x_i,
  input  logic [15:0]      cell_y_i,
  input  logic             layer_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output mmx_pkg::mmx_cmd_t cmd_o,
  output logic [AW-1:0]    cmd_addr_o
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_MUL  = 5'b00100,
    F_SUM  = 5'b01000,
    F_SEND = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;

  logic        is_load_q;
  logic [7:0]  data_q;
  logic [15:0] xs_q, ys_q;
  logic [8:0]  rx_q, ry_q;
  logic [3:0]  cnt_q;
  logic [4:0]  col_q;
  logic [3:0]  row_q;
  logic        layer_q;
  logic [15:0] prod_q, wh_q, idx_q;

  logic        accept;
  logic [9:0]  rx_sh, ry_sh;
  logic [8:0]  rx_next, ry_next;
  logic [17:0] prod_full, wh_full;
  logic [16:0] low_sum;
  logic [15:0] up_sum;
  logic [16:0] addr_wide;

  assign full_o = (state_q != F_IDLE);
  assign accept = push_i && !full_o;

  // One bit of each remainder a cycle
  assign rx_sh   = {rx_q, xs_q[15]};
  assign ry_sh   = {ry_q, ys_q[15]};
  assign rx_next = (rx_sh >= {1'b0, cfg_i.width})  ? 9'(rx_sh - {1'b0, cfg_i.width})
                                                  : rx_sh[8:0];
  assign ry_next = (ry_sh >= {1'b0, cfg_i.height}) ? 9'(ry_sh - {1'b0, cfg_i.height})
                                                  : ry_sh[8:0];

  assign prod_full = ry_q * cfg_i.width;
  assign wh_full   = cfg_i.width * cfg_i.height;
  assign low_sum   = {8'b0, rx_q} + {1'b0, prod_q};
  assign up_sum    = low_sum[15:0] + wh_q;

  // Word tiles take the high byte at twice the index
  assign addr_wide = (is_load_q || cfg_i.byte_tiles) ? {1'b0, idx_q} : {idx_q, 1'b0};

  assign cmd_valid_o       = (state_q == F_SEND);
  assign cmd_addr_o        = addr_wide[AW-1:0];
  assign cmd_o.is_load     = is_load_q;
  assign cmd_o.data        = data_q;
  assign cmd_o.col_half    = col_q;
  assign cmd_o.row_half    = row_q;
  assign cmd_o.layer       = layer_q;
  assign cmd_o.zero_tile   = layer_q && !cfg_i.has_upper;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = mode_i ? F_DIV : F_SEND;
        end
      end
      F_DIV: begin
        if (cnt_q == '0) begin
          state_d = F_MUL;
        end
      end
      F_MUL:  state_d = F_SUM;
      F_SUM:  state_d = F_SEND;
      F_SEND: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          is_load_q <= !mode_i;
          data_q    <= load_byte_i;
          idx_q     <= {2'b0, load_address_i};
          xs_q      <= cell_x_i;
          ys_q      <= cell_y_i;
          rx_q      <= '0;
          ry_q      <= '0;
          cnt_q     <= '1;
          col_q     <= cell_x_i[4:0];
          row_q     <= cell_y_i[3:0];
          layer_q   <= layer_i;
        end
      end
      F_DIV: begin
        rx_q  <= rx_next;
        ry_q  <= ry_next;
        xs_q  <= {xs_q[14:0], 1'b0};
        ys_q  <= {ys_q[14:0], 1'b0};
        cnt_q <= cnt_q - 4'd1;
      end
      F_MUL: begin
        prod_q <= prod_full[15:0];
        wh_q   <= wh_full[15:0];
      end
      F_SUM: begin
        idx_q <= layer_q ? up_sum : low_sum[15:0];
      end
      default: begin
      end
    endcase
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIV |-> (rx_q < cfg_i.width) && (ry_q < cfg_i.height))
    else $error("remainder reached the divisor");

  a_draw_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_i |=> state_q == F_DIV)
    else $error("draw item did not start the wrap");

endmodule

@@ rtl/mmx_back.sv @@
// Back part: holds the map store, carries out loads and fetches, and expands a tile
// into its four 8x8 writes. Depends on mmx_pkg for the shared types.
module mmx_back #(
  parameter int unsigned MAP_BYTES = mmx_pkg::MAP_BYTES_DFLT,
  localparam int unsigned AW       = $clog2(MAP_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmx_pkg::mmx_cfg_t cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  mmx_pkg::mmx_cmd_t cmd_i,
  input  logic [AW-1:0]     cmd_addr_i,
  output logic              res_push_o,
  input  logic              res_full_i,
  output mmx_pkg::mmx_res_t res_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FIRST  = 4'b0010,
    S_SECOND = 4'b0100,
    S_EMIT   = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [7:0]    mem_q [MAP_BYTES];
  logic [7:0]    rd_data_q;
  logic          mem_we, rd_en;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] addr_q, addr_d;
  logic [8:0]    tile_q, tile_d;
  logic [1:0]    k_q, k_d;
  logic          plane_q, plane_d;
  logic [4:0]    col_q, col_d;
  logic [3:0]    row_q, row_d;
  logic [10:0]   base_sum;

  // Doubled tile number laid out in a 16-wide set, rows 32 tiles apart
  assign base_sum = cfg_i.tile_base + {tile_q[8:3], 1'b0, tile_q[2:0], 1'b0};

  assign res_o.plane      = plane_q;
  assign res_o.column     = {col_q, k_q[0]};
  assign res_o.row        = {row_q, k_q[1]};
  assign res_o.tile_index = base_sum + {6'b0, k_q[1], 3'b0, k_q[0]};
  assign res_o.last       = (k_q == 2'd3);

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = addr_q;
    res_push_o = 1'b0;
    addr_d     = addr_q;
    tile_d     = tile_q;
    k_d        = k_q;
    plane_d    = plane_q;
    col_d      = col_q;
    row_d      = row_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          addr_d    = cmd_addr_i;
          plane_d   = cmd_i.layer || cfg_i.use_plane_a;
          col_d     = cmd_i.col_half;
          row_d     = cmd_i.row_half;
          k_d       = '0;
          if (cmd_i.is_load) begin
            mem_we = 1'b1;
          end else if (cmd_i.zero_tile) begin
            tile_d  = '0;
            state_d = S_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cmd_addr_i;
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (cfg_i.byte_tiles) begin
          tile_d  = {1'b0, rd_data_q};
          state_d = S_EMIT;
        end else begin
          // keep bit 0 of the high byte, fetch the low one
          tile_d  = {rd_data_q[0], 8'b0};
          rd_en   = 1'b1;
          rd_addr = {addr_q[AW-1:1], 1'b1};
          state_d = S_SECOND;
        end
      end
      S_SECOND: begin
        tile_d  = {tile_q[8], rd_data_q};
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          k_d        = k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    tile_q  <= tile_d;
    plane_q <= plane_d;
    col_q   <= col_d;
    row_q   <= row_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_addr_i] <= cmd_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.last |=> state_q == S_IDLE)
    else $error("sequencer did not return after the fourth write");

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SECOND |-> $past(state_q) == S_FIRST)
    else $error("low byte fetch without a high byte fetch");

endmodule

@@ rtl/metatile_map_expander.sv @@
// A draw item passes the front states (remainder, multiply, sum, send), the command queue,
// one store fetch for byte tiles or two for word tiles (none for the absent upper layer) and
// the result queue; a load item passes the send state and the command queue to the store.
// The front takes no new item until it has sent the last one; its 16-step remainder unit
// paces draw items. Four writes follow each draw item, one a cycle while the result queue
// has room. Reset clears control state and the registers (map size 1x1, others 0); the store is left undefined.
module metatile_map_expander #(
  parameter int unsigned MAP_BYTES = mmx_pkg::MAP_BYTES_DFLT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode_i,
  input  logic [13:0]                    load_address_i,
  input  logic [7:0]                     load_byte_i,
  input  logic [15:0]                    cell_x_i,
  input  logic [15:0]                    cell_y_i,
  input  logic                           layer_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           plane_o,
  output logic [5:0]                     column_o,
  output logic [4:0]                     row_o,
  output logic [10:0]                    tile_index_o,
  output logic                           last_o
);

  localparam int unsigned AW    = $clog2(MAP_BYTES);
  localparam int unsigned CMD_W = AW + $bits(mmx_pkg::mmx_cmd_t);
  localparam int unsigned RES_W = $bits(mmx_pkg::mmx_res_t);

  logic [8:0]  width_q, height_q;
  logic        has_upper_q, use_plane_a_q, byte_tiles_q;
  logic [10:0] tile_base_q;
  mmx_pkg::mmx_cfg_t cfg;

  logic              f_cmd_valid, q_full, q_empty, b_pop;
  mmx_pkg::mmx_cmd_t f_cmd, b_cmd;
  logic [AW-1:0]     f_addr, b_addr;
  logic [CMD_W-1:0]  q_out;

  logic              res_push, res_full;
  mmx_pkg::mmx_res_t b_res, out_res;
  logic [RES_W-1:0]  res_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= 9'd1;
      height_q      <= 9'd1;
      has_upper_q   <= 1'b0;
      use_plane_a_q <= 1'b0;
      byte_tiles_q  <= 1'b0;
      tile_base_q   <= '0;
    end else if (cfg_we_i) begin
      case (mmx_pkg::mmx_reg_e'(cfg_idx_i))
        mmx_pkg::REG_MAP_WIDTH:   width_q       <= cfg_data_i[8:0];
        mmx_pkg::REG_MAP_HEIGHT:  height_q      <= cfg_data_i[8:0];
        mmx_pkg::REG_HAS_UPPER:   has_upper_q   <= cfg_data_i[0];
        mmx_pkg::REG_USE_PLANE_A: use_plane_a_q <= cfg_data_i[0];
        mmx_pkg::REG_BYTE_TILES:  byte_tiles_q  <= cfg_data_i[0];
        mmx_pkg::REG_TILE_BASE:   tile_base_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Zero acts as 1, anything above 256 as 256
  always_comb begin
    cfg.width = width_q;
    if (width_q == '0) begin
      cfg.width = 9'd1;
    end else if (width_q[8] && (width_q[7:0] != '0)) begin
      cfg.width = 9'd256;
    end
    cfg.height = height_q;
    if (height_q == '0) begin
      cfg.height = 9'd1;
    end else if (height_q[8] && (height_q[7:0] != '0)) begin
      cfg.height = 9'd256;
    end
    cfg.has_upper   = has_upper_q;
    cfg.use_plane_a = use_plane_a_q;
    cfg.byte_tiles  = byte_tiles_q;
    cfg.tile_base   = tile_base_q;
  end

  mmx_front #(.MAP_BYTES(MAP_BYTES)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg),
    .push_i         (push),
    .full_o         (full),
    .mode_i,
    .load_address_i,
    .load_byte_i,
    .cell_x_i,
    .cell_y_i,
    .layer_i,
    .cmd_valid_o    (f_cmd_valid),
    .cmd_ready_i    (!q_full),
    .cmd_o          (f_cmd),
    .cmd_addr_o     (f_addr)
  );

  mmx_fifo #(.W(CMD_W), .DEPTH(mmx_pkg::CMDQ_DEPTH)) u_cmdq (
    .clk_i,
    .rst_ni,
    .push_i  (f_cmd_valid),
    .full_o  (q_full),
    .data_i  ({f_addr, f_cmd}),
    .pop_i   (b_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  assign b_addr = q_out[CMD_W-1 -: AW];
  assign b_cmd  = q_out[$bits(mmx_pkg::mmx_cmd_t)-1:0];

  mmx_back #(.MAP_BYTES(MAP_BYTES)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (b_pop),
    .cmd_i       (b_cmd),
    .cmd_addr_i  (b_addr),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (b_res)
  );

  mmx_fifo #(.W(RES_W), .DEPTH(mmx_pkg::RESQ_DEPTH)) u_resq (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (b_res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_vec)
  );

  assign out_res      = res_vec;
  assign plane_o      = out_res.plane;
  assign column_o     = out_res.column;
  assign row_o        = out_res.row;
  assign tile_index_o = out_res.tile_index;
  assign last_o       = out_res.last;

endmodule

@@ dv/tb.sv @@
// Testbench for the metatile map expander: a directed table, then random map phases.
// Predicts every tile write in-house and checks each one as it pops.
// Depends on rtl/mmx_pkg.sv and rtl/metatile_map_expander.sv.
module tb;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned ITEM_TARGET = 220;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned LONG_HOLD = 400;
  localparam mmx_pkg::mmx_res_t NO_WRITE = '0;

  typedef enum logic [1:0] {ROW_LOAD, ROW_DRAW, ROW_REG} row_kind_e;

  typedef struct packed {
    logic        mode;
    logic [13:0] address;
    logic [7:0]  data;
    logic [15:0] x;
    logic [15:0] y;
    logic        layer;
  } map_item_t;

  typedef struct {
    row_kind_e         kind;
    mmx_pkg::mmx_reg_e reg_sel;
    logic [15:0]       arg0;
    logic [15:0]       arg1;
    logic              layer;
    bit                typed;
    mmx_pkg::mmx_res_t first;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [mmx_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [mmx_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           push = 1'b0;
  logic                           full;
  logic                           mode_i = 1'b0;
  logic [13:0]                    load_address_i = '0;
  logic [7:0]                     load_byte_i = '0;
  logic [15:0]                    cell_x_i = '0;
  logic [15:0]                    cell_y_i = '0;
  logic                           layer_i = 1'b0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic                           plane_o;
  logic [5:0]                     column_o;
  logic [4:0]                     row_o;
  logic [10:0]                    tile_index_o;
  logic                           last_o;

  metatile_map_expander dut (.*);

  // Shadow of the map store and of the registers
  logic [7:0]  map_copy [mmx_pkg::MAP_BYTES_DFLT];
  bit          map_known [mmx_pkg::MAP_BYTES_DFLT];
  logic [8:0]  cfg_width = 9'd1;
  logic [8:0]  cfg_height = 9'd1;
  logic        cfg_upper = 1'b0;
  logic        cfg_plane_a = 1'b0;
  logic        cfg_byte = 1'b0;
  logic [10:0] cfg_base = '0;

  mmx_pkg::mmx_res_t writes_due [$];
  mmx_pkg::mmx_res_t due_write;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_served = 0;
  int unsigned pop_wait = 0;
  int unsigned writes_seen = 0;
  bit          feed_calm = 1'b0;
  bit          drain_calm = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Store bytes that a draw of this cell reads: none, one, or high then low byte
  function automatic void tile_addresses(input logic [15:0] x, input logic [15:0] y,
                                         input logic layer, output int unsigned n,
                                         output logic [13:0] a_hi, output logic [13:0] a_lo);
    int unsigned w, h, idx;
    w = (cfg_width == 0) ? 1 : (cfg_width > 256) ? 256 : cfg_width;
    h = (cfg_height == 0) ? 1 : (cfg_height > 256) ? 256 : cfg_height;
    idx = ((x % w) + (y % h) * w) & 32'hFFFF;
    n = 0;
    a_hi = '0;
    a_lo = '0;
    if (layer && !cfg_upper) return;
    if (layer) idx = (idx + w * h) & 32'hFFFF;
    if (cfg_byte) begin
      n = 1;
      a_lo = 14'(idx % mmx_pkg::MAP_BYTES_DFLT);
      a_hi = a_lo;
    end else begin
      n = 2;
      a_hi = 14'((idx * 2) % mmx_pkg::MAP_BYTES_DFLT);
      a_lo = 14'((idx * 2 + 1) % mmx_pkg::MAP_BYTES_DFLT);
    end
  endfunction

  // Queue the four writes of a 2x2 metatile from its top-left write
  function automatic void queue_metatile(logic plane, logic [5:0] col, logic [4:0] row,
                                         logic [10:0] base);
    mmx_pkg::mmx_res_t w;
    for (int k = 0; k < 4; k++) begin
      w.plane      = plane;
      w.column     = col + 6'(k % 2);
      w.row        = row + 5'(k / 2);
      w.tile_index = base + 11'(k % 2) + 11'(16 * (k / 2));
      w.last       = (k == 3);
      writes_due.push_back(w);
    end
  endfunction

  function automatic void predict_metatile(map_item_t c);
    int unsigned n, tile, t, b;
    logic [13:0] a_hi, a_lo;
    tile_addresses(c.x, c.y, c.layer, n, a_hi, a_lo);
    tile = (n == 0) ? 0 : (n == 1) ? map_copy[a_lo] : {map_copy[a_hi], map_copy[a_lo]};
    t = (tile * 2) & 32'hFFFF;
    b = cfg_base + (t / 16) * 32 + t % 16;
    queue_metatile(c.layer ? 1'b1 : cfg_plane_a, 6'(c.x * 2), 5'(c.y * 2), 11'(b));
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  task automatic idle(int unsigned n);
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_item(map_item_t c, bit typed, mmx_pkg::mmx_res_t first);
    mode_i         <= c.mode;
    load_address_i <= c.address;
    load_byte_i    <= c.data;
    cell_x_i       <= c.x;
    cell_y_i       <= c.y;
    layer_i        <= c.layer;
    push           <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (c.mode == MODE_LOAD) begin
      map_copy[c.address]  = c.data;
      map_known[c.address] = 1'b1;
    end else if (typed) begin
      queue_metatile(first.plane, first.column, first.row, first.tile_index);
    end else begin
      predict_metatile(c);
    end
  endtask

  task automatic feed_load(logic [13:0] address, logic [7:0] data);
    map_item_t c;
    c = '{mode: MODE_LOAD, address: address, data: data, default: '0};
    send_item(c, 1'b0, NO_WRITE);
    idle(feed_calm ? 0 : pick_gap());
  endtask

  // Load any byte the cell reads that was never written, then draw it
  task automatic draw_cell(logic [15:0] x, logic [15:0] y, logic layer, bit typed,
                           mmx_pkg::mmx_res_t first);
    int unsigned n;
    logic [13:0] a_hi, a_lo;
    map_item_t c;
    tile_addresses(x, y, layer, n, a_hi, a_lo);
    if (n != 0 && !map_known[a_hi]) feed_load(a_hi, 8'($urandom));
    if (n == 2 && !map_known[a_lo]) feed_load(a_lo, 8'($urandom));
    c = '{mode: MODE_DRAW, x: x, y: y, layer: layer, default: '0};
    send_item(c, typed, first);
    idle(feed_calm ? 0 : pick_gap());
  endtask

  // Drain every due write, then give in-flight loads time to land
  task automatic settle();
    push <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(mmx_pkg::mmx_reg_e r, logic [10:0] d);
    cfg_idx_i  <= r;
    cfg_data_i <= d;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (r)
      mmx_pkg::REG_MAP_WIDTH:   cfg_width   = d[8:0];
      mmx_pkg::REG_MAP_HEIGHT:  cfg_height  = d[8:0];
      mmx_pkg::REG_HAS_UPPER:   cfg_upper   = d[0];
      mmx_pkg::REG_USE_PLANE_A: cfg_plane_a = d[0];
      mmx_pkg::REG_BYTE_TILES:  cfg_byte    = d[0];
      mmx_pkg::REG_TILE_BASE:   cfg_base    = d;
      default: ;
    endcase
  endtask

  function automatic logic [10:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd256;
      3: return 11'($urandom);
      default: return 11'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 31));
    endcase
  endfunction

  // Result side: check each popped write, hold off at random
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (writes_due.size() == 0) begin
        mismatches++;
        $display("%0t: write with none due: plane %0d col %0d row %0d tile %0d last %0d",
                 $time, plane_o, column_o, row_o, tile_index_o, last_o);
      end else begin
        due_write = writes_due.pop_front();
        check_field("plane", due_write.plane, plane_o);
        check_field("column", due_write.column, column_o);
        check_field("row", due_write.row, row_o);
        check_field("tile_index", due_write.tile_index, tile_index_o);
        check_field("last", due_write.last, last_o);
      end
      writes_seen++;
      if (writes_seen % 24 == 0) drain_calm = ($urandom_range(0, 3) == 0);
      pop_wait = drain_calm ? 0 : pick_gap();
    end else if (pop_wait != 0) begin
      pop_wait--;
    end
    if (holds_served != hold_asks) begin
      holds_served = hold_asks;
      pop_wait = LONG_HOLD;
    end
    pop <= rst_ni && (pop_wait == 0);
  end

  initial begin
    dir_row_t    script [$];
    int unsigned quota_end, step;
    logic [10:0] w_val, h_val;

    script = '{
      '{ROW_LOAD, mmx_pkg::REG_MAP_WIDTH, 16'h0000, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_LOAD, mmx_pkg::REG_MAP_WIDTH, 16'h0001, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'h0000, 16'h0000, 1'b0, 1'b1,
        '{1'b0, 6'd0, 5'd0, 11'd0, 1'b0}},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1,
        '{1'b0, 6'd62, 5'd30, 11'd0, 1'b0}},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'h0000, 16'h0000, 1'b1, 1'b1,
        '{1'b1, 6'd0, 5'd0, 11'd0, 1'b0}},
      '{ROW_LOAD, mmx_pkg::REG_MAP_WIDTH, 16'h0000, 16'h00FF, 1'b0, 1'b0, NO_WRITE},
      '{ROW_LOAD, mmx_pkg::REG_MAP_WIDTH, 16'h0001, 16'h00FF, 1'b0, 1'b0, NO_WRITE},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'h0005, 16'h0007, 1'b0, 1'b1,
        '{1'b0, 6'd10, 5'd14, 11'd2030, 1'b0}},
      '{ROW_REG, mmx_pkg::REG_TILE_BASE, 16'd2047, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_BYTE_TILES, 16'd1, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_MAP_WIDTH, 16'd300, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_MAP_HEIGHT, 16'd511, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_HAS_UPPER, 16'd1, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_USE_PLANE_A, 16'd1, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_LOAD, mmx_pkg::REG_MAP_WIDTH, 16'h3FFF, 16'h00A5, 1'b0, 1'b0, NO_WRITE},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'd255, 16'd63, 1'b0, 1'b0, NO_WRITE},
      // upper offset of 256*256 wraps back onto the lower cell
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'd255, 16'd63, 1'b1, 1'b0, NO_WRITE},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'h0000, 16'h0000, 1'b1, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_MAP_WIDTH, 16'd0, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_MAP_HEIGHT, 16'd0, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_USE_PLANE_A, 16'd0, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'd1234, 16'd4321, 1'b1, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_BYTE_TILES, 16'd0, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_REG, mmx_pkg::REG_TILE_BASE, 16'd0, 16'h0000, 1'b0, 1'b0, NO_WRITE},
      '{ROW_DRAW, mmx_pkg::REG_MAP_WIDTH, 16'h0000, 16'h0000, 1'b1, 1'b0, NO_WRITE}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_REG: begin
          settle();
          write_reg(script[i].reg_sel, 11'(script[i].arg0));
        end
        ROW_LOAD: feed_load(14'(script[i].arg0), 8'(script[i].arg1));
        default: draw_cell(script[i].arg0, script[i].arg1, script[i].layer, script[i].typed,
                           script[i].first);
      endcase
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          w_val = 11'h7FF;
          h_val = 11'd256;
        end
        1: begin
          w_val = 11'd0;
          h_val = 11'd0;
        end
        default: begin
          w_val = pick_dim();
          h_val = pick_dim();
        end
      endcase
      write_reg(mmx_pkg::REG_MAP_WIDTH, w_val);
      write_reg(mmx_pkg::REG_MAP_HEIGHT, h_val);
      write_reg(mmx_pkg::REG_HAS_UPPER, (phase < 2) ? 11'(phase == 0) : 11'($urandom));
      write_reg(mmx_pkg::REG_USE_PLANE_A, (phase < 2) ? 11'(phase == 1) : 11'($urandom));
      write_reg(mmx_pkg::REG_BYTE_TILES, (phase < 2) ? 11'(phase == 1) : 11'($urandom));
      write_reg(mmx_pkg::REG_TILE_BASE,
                (phase == 0) ? 11'd2047 : (phase == 1) ? 11'd0 : 11'($urandom));

      quota_end = (phase + 1) * ITEM_TARGET / N_PHASES;
      step = 0;
      while (items_sent < quota_end) begin
        if (step % 16 == 0) feed_calm = ($urandom_range(0, 3) == 0);
        // ask for a long hold on the result side and keep offering items meanwhile
        if (phase == 2 && step == 4) hold_asks++;
        if (phase == 2 && step >= 4 && step < 40) feed_calm = 1'b1;
        if ($urandom_range(0, 9) < 3)
          feed_load(14'($urandom), 8'($urandom));
        else
          draw_cell(pick_coord(), pick_coord(), 1'($urandom), 1'b0, NO_WRITE);
        step++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
